### src/tcp_pkg.sv
// Shared types, constants and arithmetic helpers for the tag-count probability block.
// Depends on nothing; used by tcp_recur, tcp_accum and tag_count_probability.
`timescale 1ns / 1ps

package tcp_pkg;

    localparam int PROB_W  = 16;
    localparam int TOTAL_W = 39;
    localparam int LOW_BINS = 3;

    localparam logic [PROB_W-1:0]  ONE_Q15   = 16'h8000;
    localparam logic [31:0]        HALF_Q15  = 32'h0000_4000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef logic [PROB_W-1:0]  prob_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef struct packed {
        prob_t p0;
        prob_t p1;
        prob_t p2;
    } probs_t;

    // One recurrence step: stay*(1-e) + shift_in*(e), rounded half up in Q1.15.
    // Inputs never exceed 1.0, so the sum stays below 2^31 and the result below 2^16.
    function automatic prob_t blend(input prob_t stay, input prob_t shift_in, input prob_t e);
        logic [31:0] keep_term;
        logic [31:0] move_term;
        logic [31:0] acc;
        begin
            keep_term = 32'(stay) * 32'(ONE_Q15 - e);
            move_term = 32'(shift_in) * 32'(e);
            acc       = keep_term + move_term + HALF_Q15;
            blend     = acc[30:15];
        end
    endfunction

endpackage

### src/tcp_recur.sv
// Per-jet recurrence stage: running tag-count probabilities and per-event capture.
// Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_recur #(
    parameter int TAG_BINS = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            a_valid,
    input  tcp_pkg::prob_t  eff,
    input  logic            last,
    input  logic            empty,
    output logic            b_valid,
    output tcp_pkg::probs_t b_probs
);

    localparam int CALC_BINS = (TAG_BINS < tcp_pkg::LOW_BINS) ? TAG_BINS : tcp_pkg::LOW_BINS;

    tcp_pkg::prob_t  run_zero_reg, run_one_reg, run_two_reg;
    tcp_pkg::prob_t  n0, n1, n2;
    tcp_pkg::probs_t b_probs_reg;
    logic            b_valid_reg;

    always_comb
    begin
        n0 = (CALC_BINS > 0) ? tcp_pkg::blend(run_zero_reg, '0, eff) : '0;
        n1 = (CALC_BINS > 1) ? tcp_pkg::blend(run_one_reg, run_zero_reg, eff) : '0;
        n2 = (CALC_BINS > 2) ? tcp_pkg::blend(run_two_reg, run_one_reg, eff) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_zero_reg <= (CALC_BINS > 0) ? tcp_pkg::ONE_Q15 : '0;
            run_one_reg  <= '0;
            run_two_reg  <= '0;
            b_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid && (empty || last);
            if (a_valid)
            begin
                // start a fresh event once this one finishes or is empty
                if (empty || last)
                begin
                    run_zero_reg <= (CALC_BINS > 0) ? tcp_pkg::ONE_Q15 : '0;
                    run_one_reg  <= '0;
                    run_two_reg  <= '0;
                end
                else
                begin
                    run_zero_reg <= n0;
                    run_one_reg  <= n1;
                    run_two_reg  <= n2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid)
        begin
            if (empty)
                b_probs_reg <= '0;
            else
            begin
                b_probs_reg.p0 <= n0;
                b_probs_reg.p1 <= n1;
                b_probs_reg.p2 <= n2;
            end
        end
    end

    assign b_valid = b_valid_reg;
    assign b_probs = b_probs_reg;

endmodule

### src/tcp_accum.sv
// Result stage: remainder probability, saturating totals and the output register.
// Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            b_valid,
    input  tcp_pkg::probs_t b_probs,
    output logic            out_valid,
    output tcp_pkg::prob_t  prob_zero,
    output tcp_pkg::prob_t  prob_one,
    output tcp_pkg::prob_t  prob_two,
    output tcp_pkg::prob_t  prob_three_plus,
    output tcp_pkg::total_t total_zero,
    output tcp_pkg::total_t total_one,
    output tcp_pkg::total_t total_two,
    output tcp_pkg::total_t total_three_plus
);

    logic [17:0]     used;
    tcp_pkg::prob_t  p3;
    tcp_pkg::total_t tot0_next, tot1_next, tot2_next, tot3_next;
    tcp_pkg::total_t tot0_reg, tot1_reg, tot2_reg, tot3_reg;
    tcp_pkg::prob_t  p0_reg, p1_reg, p2_reg, p3_reg;
    logic            out_valid_reg;

    function automatic tcp_pkg::total_t sat_add(input tcp_pkg::total_t a,
                                                input tcp_pkg::prob_t b);
        logic [tcp_pkg::TOTAL_W:0] s;
        begin
            s = {1'b0, a} + (tcp_pkg::TOTAL_W+1)'(b);
            sat_add = s[tcp_pkg::TOTAL_W] ? tcp_pkg::TOTAL_MAX : s[tcp_pkg::TOTAL_W-1:0];
        end
    endfunction

    always_comb
    begin
        used = 18'(b_probs.p0) + 18'(b_probs.p1) + 18'(b_probs.p2);
        // rounding can push the three past one; clamp the remainder at zero
        p3 = (used >= 18'(tcp_pkg::ONE_Q15)) ? '0 : 16'(18'(tcp_pkg::ONE_Q15) - used);
        tot0_next = sat_add(tot0_reg, b_probs.p0);
        tot1_next = sat_add(tot1_reg, b_probs.p1);
        tot2_next = sat_add(tot2_reg, b_probs.p2);
        tot3_next = sat_add(tot3_reg, p3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tot0_reg      <= '0;
            tot1_reg      <= '0;
            tot2_reg      <= '0;
            tot3_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid;
            if (b_valid)
            begin
                tot0_reg <= tot0_next;
                tot1_reg <= tot1_next;
                tot2_reg <= tot2_next;
                tot3_reg <= tot3_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid)
        begin
            p0_reg <= b_probs.p0;
            p1_reg <= b_probs.p1;
            p2_reg <= b_probs.p2;
            p3_reg <= p3;
        end
    end

    assign out_valid        = out_valid_reg;
    assign prob_zero        = p0_reg;
    assign prob_one         = p1_reg;
    assign prob_two         = p2_reg;
    assign prob_three_plus  = p3_reg;
    assign total_zero       = tot0_reg;
    assign total_one        = tot1_reg;
    assign total_two        = tot2_reg;
    assign total_three_plus = tot3_reg;

endmodule

### src/tag_count_probability.sv
// Top level of the tag-count probability block: input register, recurrence and result stages.
// Depends on tcp_pkg, tcp_recur and tcp_accum.
`timescale 1ns / 1ps

// Takes one jet efficiency (Q1.15, values above 1.0 clamp to 1.0) per cycle while in_ready
// is high and keeps the probabilities that exactly 0, 1 or 2 jets of the current event are
// tagged. One result leaves per event once its last jet (or its empty-event marker) has
// passed all three registers: p0, p1, p2, the clamped remainder p3plus, and saturating
// totals of all four over every finished event. The pipeline is three register stages (input,
// recurrence, result) and takes a new jet every cycle unless a result waits at the output,
// when all stages hold. Feedback is the per-jet multiply-add and the saturating totals.
// TAG_BINS limits which tag counts below three are computed; the rest fold into p3plus.
module tag_count_probability #(
    parameter int TAG_BINS = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tcp_pkg::prob_t  efficiency,
    input  logic            last_jet,
    input  logic            no_jets,
    output logic            out_valid,
    input  logic            out_ready,
    output tcp_pkg::prob_t  prob_zero,
    output tcp_pkg::prob_t  prob_one,
    output tcp_pkg::prob_t  prob_two,
    output tcp_pkg::prob_t  prob_three_plus,
    output tcp_pkg::total_t total_zero,
    output tcp_pkg::total_t total_one,
    output tcp_pkg::total_t total_two,
    output tcp_pkg::total_t total_three_plus
);

    logic            advance;
    logic            a_valid_reg;
    tcp_pkg::prob_t  eff_reg;
    logic            last_reg;
    logic            empty_reg;
    logic            b_valid;
    tcp_pkg::probs_t b_probs;

    // advance every stage unless a finished result is still waiting
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            eff_reg   <= (efficiency > tcp_pkg::ONE_Q15) ? tcp_pkg::ONE_Q15 : efficiency;
            last_reg  <= last_jet;
            empty_reg <= no_jets;
        end
    end

    tcp_recur #(
        .TAG_BINS (TAG_BINS)
    ) u_recur (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .a_valid (a_valid_reg),
        .eff     (eff_reg),
        .last    (last_reg),
        .empty   (empty_reg),
        .b_valid (b_valid),
        .b_probs (b_probs)
    );

    tcp_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .b_valid          (b_valid),
        .b_probs          (b_probs),
        .out_valid        (out_valid),
        .prob_zero        (prob_zero),
        .prob_one         (prob_one),
        .prob_two         (prob_two),
        .prob_three_plus  (prob_three_plus),
        .total_zero       (total_zero),
        .total_one        (total_one),
        .total_two        (total_two),
        .total_three_plus (total_three_plus)
    );

endmodule
